FILE: rtl/hkre_pkg.sv
// ============================================================================
// hkre_pkg
// Shared types and constants of the HID keyboard report engine.
// ============================================================================
`default_nettype none

package hkre_pkg;

    localparam int NUM_MODS  = 8;
    localparam int NUM_SLOTS = 6;

    localparam logic [1:0] REPEAT_COUNT  = 2'd2;
    localparam logic [7:0] TICK_MS_RESET = 8'h01;

    typedef logic [7:0] t_code;
    typedef logic [6:0] t_hold;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_MOD   = 2'd1,
        ACT_KEY   = 2'd2,
        ACT_DELAY = 2'd3
    } t_action;

    // arg holds {code, hold} for presses, the delay in ms for a delay
    typedef struct packed {
        t_action     action;
        logic [14:0] arg;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    typedef struct packed {
        logic [7:0]                  mods;
        logic [NUM_SLOTS-1:0][7:0]   keys;
    } t_report;

    // front -> back
    typedef struct packed {
        logic tick;
        logic empty;
        t_cmd cmd;
    } t_front_stat;

    // back -> front
    typedef struct packed {
        logic busy;
        logic pop;
    } t_back_ctl;

endpackage

`default_nettype wire

FILE: rtl/hkre_ram.sv
// ============================================================================
// hkre_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module hkre_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/hkre_front.sv
// ============================================================================
// hkre_front
// Accepts items, queues press and delay commands, flags ticks to the back end.
// ============================================================================
`default_nettype none

module hkre_front #(
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [1:0]           i_action,
    input  wire logic [7:0]           i_code,
    input  wire logic [6:0]           i_hold_ticks,
    input  wire logic [14:0]          i_delay_ms,
    input  wire hkre_pkg::t_back_ctl  i_ctl,
    output hkre_pkg::t_front_stat     o_stat
);

    import hkre_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             accept;
    logic             push;
    t_cmd             wcmd;
    logic [CMD_W-1:0] rdata;

    assign accept = i_start && !i_ctl.busy;
    // drop the whole command when the queue is full
    assign push   = accept && (t_action'(i_action) != ACT_TICK) && (r_cnt != CNT_FULL);

    always_comb begin
        wcmd.action = t_action'(i_action);
        if (t_action'(i_action) == ACT_DELAY) begin
            wcmd.arg = i_delay_ms;
        end else begin
            wcmd.arg = {i_code, i_hold_ticks};
        end
    end

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_ctl.pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (push && !i_ctl.pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_ctl.pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    hkre_ram #(
        .WIDTH (CMD_W),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_wr),
        .i_wdata (wcmd),
        .i_raddr (r_rd),
        .o_rdata (rdata)
    );

    assign o_stat.tick  = accept && (t_action'(i_action) == ACT_TICK);
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.cmd   = t_cmd'(rdata);

endmodule

`default_nettype wire

FILE: rtl/hkre_back.sv
// ============================================================================
// hkre_back
// Drains queued commands on a tick, runs the delay timer, builds the report
// and ages the modifier and key release counters.
// ============================================================================
`default_nettype none

module hkre_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [7:0]            i_tick_ms,
    input  wire hkre_pkg::t_front_stat i_stat,
    output hkre_pkg::t_back_ctl        o_ctl,
    output logic                       o_valid,
    output logic                       o_report_sent,
    output hkre_pkg::t_report          o_report,
    output logic                       o_all_released
);

    import hkre_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FETCH  = 4'b0010,
        ST_EXEC   = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic        r_delay_active, n_delay_active;
    logic [16:0] r_delay_rem, n_delay_rem;
    t_hold       r_mod_cnt [NUM_MODS], n_mod_cnt [NUM_MODS];
    logic [7:0]  r_mod_bits, n_mod_bits;
    t_code       r_slot_code [NUM_SLOTS], n_slot_code [NUM_SLOTS];
    t_hold       r_slot_cnt [NUM_SLOTS], n_slot_cnt [NUM_SLOTS];
    t_report     r_last, n_last;
    logic [1:0]  r_repeat, n_repeat;
    logic        r_valid, n_valid;
    logic        r_sent, n_sent;
    t_report     r_report, n_report;
    logic        r_released, n_released;

    logic        pop;
    t_code       cmd_code;
    t_hold       cmd_hold;
    logic [2:0]  key_slot;
    logic        key_found;
    t_report     cur;
    logic        sent;
    t_hold       mod_dec [NUM_MODS];
    t_hold       slot_dec [NUM_SLOTS];
    logic [2:0]  pos;
    logic        released;

    assign cmd_code = i_stat.cmd.arg[14:7];
    assign cmd_hold = i_stat.cmd.arg[6:0];

    // first slot holding the same code or free
    always_comb begin
        key_slot  = '0;
        key_found = 1'b0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (r_slot_code[s] == cmd_code || r_slot_cnt[s] == '0) begin
                key_slot  = 3'(s);
                key_found = 1'b1;
            end
        end
    end

    always_comb begin
        cur.mods = r_mod_bits;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            cur.keys[i] = r_slot_code[i];
        end
    end

    always_comb begin
        n_state        = r_state;
        n_delay_active = r_delay_active;
        n_delay_rem    = r_delay_rem;
        n_mod_cnt      = r_mod_cnt;
        n_mod_bits     = r_mod_bits;
        n_slot_code    = r_slot_code;
        n_slot_cnt     = r_slot_cnt;
        n_last         = r_last;
        n_repeat       = r_repeat;
        n_valid        = 1'b0;
        n_sent         = r_sent;
        n_report       = r_report;
        n_released     = r_released;
        pop            = 1'b0;
        sent           = 1'b0;
        released       = 1'b1;
        pos            = '0;
        for (int i = 0; i < NUM_MODS; i++) begin
            mod_dec[i] = (r_mod_cnt[i] != '0) ? r_mod_cnt[i] - 1'b1 : '0;
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_dec[i] = (r_slot_cnt[i] != '0) ? r_slot_cnt[i] - 1'b1 : '0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_stat.tick) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (!i_stat.empty && !r_delay_active) begin
                    pop     = 1'b1;
                    n_state = ST_EXEC;
                end else begin
                    if (r_delay_active) begin
                        n_delay_rem    = r_delay_rem - {9'b0, i_tick_ms};
                        // expire once the remaining time goes negative
                        n_delay_active = !n_delay_rem[16];
                    end
                    n_state = ST_FINISH;
                end
            end
            ST_EXEC: begin
                case (i_stat.cmd.action)
                    ACT_MOD: begin
                        if (cmd_code[7:3] == '0) begin
                            if (cmd_hold != '0) begin
                                n_mod_bits[cmd_code[2:0]] = 1'b1;
                            end
                            n_mod_cnt[cmd_code[2:0]] = cmd_hold;
                        end
                    end
                    ACT_KEY: begin
                        if (cmd_code != '0 && key_found) begin
                            if (cmd_hold != '0) begin
                                n_slot_code[key_slot] = cmd_code;
                            end
                            n_slot_cnt[key_slot] = cmd_hold;
                        end
                    end
                    ACT_DELAY: begin
                        n_delay_active = 1'b1;
                        n_delay_rem    = {2'b00, i_stat.cmd.arg};
                    end
                    default: begin
                    end
                endcase
                n_state = ST_FETCH;
            end
            ST_FINISH: begin
                if (cur == r_last) begin
                    if (r_repeat != '0) begin
                        n_repeat = r_repeat - 1'b1;
                        sent     = 1'b1;
                    end
                end else begin
                    n_last   = cur;
                    n_repeat = REPEAT_COUNT;
                    sent     = 1'b1;
                end
                n_valid  = 1'b1;
                n_sent   = sent;
                n_report = sent ? cur : '0;

                // age counters, clear expired entries
                for (int i = 0; i < NUM_MODS; i++) begin
                    n_mod_cnt[i]  = mod_dec[i];
                    n_mod_bits[i] = (mod_dec[i] != '0);
                    if (mod_dec[i] != '0) begin
                        released = 1'b0;
                    end
                end
                // compact live keys toward slot 0, keeping their order
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    n_slot_code[i] = '0;
                    n_slot_cnt[i]  = '0;
                end
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_dec[i] != '0) begin
                        n_slot_code[pos] = r_slot_code[i];
                        n_slot_cnt[pos]  = slot_dec[i];
                        pos              = pos + 1'b1;
                        released         = 1'b0;
                    end
                end
                n_released = released;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_delay_active <= 1'b0;
            r_delay_rem    <= '0;
            r_mod_bits     <= '0;
            r_last         <= '0;
            r_repeat       <= '0;
            r_valid        <= 1'b0;
            for (int i = 0; i < NUM_MODS; i++) begin
                r_mod_cnt[i] <= '0;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot_code[i] <= '0;
                r_slot_cnt[i]  <= '0;
            end
        end else begin
            r_state        <= n_state;
            r_delay_active <= n_delay_active;
            r_delay_rem    <= n_delay_rem;
            r_mod_bits     <= n_mod_bits;
            r_last         <= n_last;
            r_repeat       <= n_repeat;
            r_valid        <= n_valid;
            r_mod_cnt      <= n_mod_cnt;
            r_slot_code    <= n_slot_code;
            r_slot_cnt     <= n_slot_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sent     <= n_sent;
        r_report   <= n_report;
        r_released <= n_released;
    end

    assign o_ctl.busy     = (r_state != ST_IDLE);
    assign o_ctl.pop      = pop;
    assign o_valid        = r_valid;
    assign o_report_sent  = r_sent;
    assign o_report       = r_report;
    assign o_all_released = r_released;

endmodule

`default_nettype wire

FILE: rtl/hid_keyboard_report_engine_unit.sv
// Queue items (modifier press, key press, delay) are taken while idle; busy stays low.
// A tick item holds busy high while the back end drains N commands (0..FIFO_DEPTH);
// each drained command passes through a FETCH and an EXEC state, reading the registered-read queue RAM.
// The result strobe o_valid is high for one cycle, the first cycle busy is low again.
// Synchronous active-low reset empties the queue, clears delay, counters and report
// history, and sets tick_ms to 1.
// ============================================================================
// hid_keyboard_report_engine_unit
// USB boot keyboard report engine, six key slots, APB configuration.
// ============================================================================
`default_nettype none

module hid_keyboard_report_engine_unit #(
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_code,
    input  wire logic [6:0]  i_hold_ticks,
    input  wire logic [14:0] i_delay_ms,
    output logic             o_valid,
    output logic             o_report_sent,
    output logic [7:0]       o_modifiers,
    output logic [7:0]       o_key_slot0,
    output logic [7:0]       o_key_slot1,
    output logic [7:0]       o_key_slot2,
    output logic [7:0]       o_key_slot3,
    output logic [7:0]       o_key_slot4,
    output logic [7:0]       o_key_slot5,
    output logic             o_all_released,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import hkre_pkg::*;

    logic        [7:0] r_tick_ms;
    t_front_stat       stat;
    t_back_ctl         ctl;
    t_report           report;

    // single word register: every address in the window selects tick_ms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_ms <= TICK_MS_RESET;
        end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
            r_tick_ms <= pwdata[7:0];
        end else if (psel && penable && pwrite && pready) begin
            r_tick_ms <= pwdata[7:0];
        end
    end

    assign prdata = {24'b0, r_tick_ms};
    assign pready = 1'b1;

    hkre_front #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_action     (i_action),
        .i_code       (i_code),
        .i_hold_ticks (i_hold_ticks),
        .i_delay_ms   (i_delay_ms),
        .i_ctl        (ctl),
        .o_stat       (stat)
    );

    hkre_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick_ms      (r_tick_ms),
        .i_stat         (stat),
        .o_ctl          (ctl),
        .o_valid        (o_valid),
        .o_report_sent  (o_report_sent),
        .o_report       (report),
        .o_all_released (o_all_released)
    );

    assign busy        = ctl.busy;
    assign o_modifiers = report.mods;
    assign o_key_slot0 = report.keys[0];
    assign o_key_slot1 = report.keys[1];
    assign o_key_slot2 = report.keys[2];
    assign o_key_slot3 = report.keys[3];
    assign o_key_slot4 = report.keys[4];
    assign o_key_slot5 = report.keys[5];

endmodule

`default_nettype wire

FILE: rtl/hkre_checker.sv
// ============================================================================
// hkre_checker
// Port-level checks of the report engine, bound to the top level.
// ============================================================================
`default_nettype none

module hkre_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  i_action,
    input wire logic        o_valid,
    input wire logic        o_report_sent,
    input wire logic [7:0]  o_modifiers,
    input wire logic [7:0]  o_key_slot0,
    input wire logic [7:0]  o_key_slot1,
    input wire logic [7:0]  o_key_slot2,
    input wire logic [7:0]  o_key_slot3,
    input wire logic [7:0]  o_key_slot4,
    input wire logic [7:0]  o_key_slot5
);

    import hkre_pkg::*;

    // a tick item always occupies the engine
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_TICK) |=> busy)
        else $error("tick item did not raise busy");

    // a queue item gives no result and keeps the engine free
    a_push_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action != ACT_TICK) |=> (!busy && !o_valid))
        else $error("queue item produced a result or raised busy");

    // every finished tick yields a result
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("tick finished without a result");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // no report sent: report fields read as zero
    a_unsent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_report_sent) |->
            (o_modifiers == 8'h00 && o_key_slot0 == 8'h00 && o_key_slot1 == 8'h00 &&
             o_key_slot2 == 8'h00 && o_key_slot3 == 8'h00 && o_key_slot4 == 8'h00 &&
             o_key_slot5 == 8'h00))
        else $error("report fields nonzero without a sent report");

endmodule

bind hid_keyboard_report_engine_unit hkre_checker u_hkre_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_action      (i_action),
    .o_valid       (o_valid),
    .o_report_sent (o_report_sent),
    .o_modifiers   (o_modifiers),
    .o_key_slot0   (o_key_slot0),
    .o_key_slot1   (o_key_slot1),
    .o_key_slot2   (o_key_slot2),
    .o_key_slot3   (o_key_slot3),
    .o_key_slot4   (o_key_slot4),
    .o_key_slot5   (o_key_slot5)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the HID keyboard report engine: directed presses,
// releases and delays, then random command bursts and ticks under three
// tick_ms settings, each tick result compared with a local model.
// ============================================================================

module tb;

    import hkre_pkg::*;

    localparam int         QUEUE_DEPTH = 16;
    localparam logic [1:0] REG_TICK_MS = 2'd0;
    localparam int         DRAIN_WAIT  = 2 * QUEUE_DEPTH + 4;

    typedef struct packed {
        t_action     action;
        logic [7:0]  code;
        logic [6:0]  hold;
        logic [14:0] dly;
    } t_queued_cmd;

    typedef struct packed {
        logic                      sent;
        logic [7:0]                mods;
        logic [NUM_SLOTS-1:0][7:0] keys;
        logic                      released;
    } t_tick_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [7:0]  i_code;
    logic [6:0]  i_hold_ticks;
    logic [14:0] i_delay_ms;
    logic        o_valid;
    logic        o_report_sent;
    logic [7:0]  o_modifiers;
    logic [7:0]  o_key_slot0;
    logic [7:0]  o_key_slot1;
    logic [7:0]  o_key_slot2;
    logic [7:0]  o_key_slot3;
    logic [7:0]  o_key_slot4;
    logic [7:0]  o_key_slot5;
    logic        o_all_released;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // model state
    t_queued_cmd  cmd_queue [$];
    bit           delay_pending;
    int           delay_left;
    logic [6:0]   mod_cnt [NUM_MODS];
    logic [7:0]   mod_bits;
    logic [7:0]   key_code [NUM_SLOTS];
    logic [6:0]   key_cnt [NUM_SLOTS];
    logic [7:0]   last_mods;
    logic [7:0]   last_keys [NUM_SLOTS];
    int           repeats_left;
    logic [7:0]   tick_ms_q;

    t_tick_report pending_reports [$];
    int           n_mismatch = 0;
    int           sender_idle_pct = 0;

    hid_keyboard_report_engine_unit #(
        .FIFO_DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_code        (i_code),
        .i_hold_ticks  (i_hold_ticks),
        .i_delay_ms    (i_delay_ms),
        .o_valid       (o_valid),
        .o_report_sent (o_report_sent),
        .o_modifiers   (o_modifiers),
        .o_key_slot0   (o_key_slot0),
        .o_key_slot1   (o_key_slot1),
        .o_key_slot2   (o_key_slot2),
        .o_key_slot3   (o_key_slot3),
        .o_key_slot4   (o_key_slot4),
        .o_key_slot5   (o_key_slot5),
        .o_all_released(o_all_released),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        n_mismatch++;
    endtask

    task automatic clear_keyboard_model();
        int i;
        cmd_queue.delete();
        delay_pending = 0;
        delay_left    = 0;
        for (i = 0; i < NUM_MODS; i++) mod_cnt[i] = '0;
        mod_bits = '0;
        for (i = 0; i < NUM_SLOTS; i++) begin
            key_code[i]  = '0;
            key_cnt[i]   = '0;
            last_keys[i] = '0;
        end
        last_mods    = '0;
        repeats_left = 0;
        tick_ms_q    = TICK_MS_RESET;
    endtask

    // Queue a command, or run one tick and record the report it produces.
    task automatic advance_keyboard_model(input t_queued_cmd item);
        t_queued_cmd  c;
        t_tick_report rep;
        bit           changed;
        int           i;
        int           s;
        int           t;
        rep.sent     = 1'b0;
        rep.released = 1'b1;
        if (item.action != ACT_TICK) begin
            if (cmd_queue.size() < QUEUE_DEPTH) cmd_queue.push_back(item);
        end else begin
            while (cmd_queue.size() > 0 && !delay_pending) begin
                c = cmd_queue.pop_front();
                case (c.action)
                    ACT_MOD: begin
                        if (c.code < NUM_MODS) begin
                            if (c.hold != 0) mod_bits[c.code[2:0]] = 1'b1;
                            mod_cnt[c.code[2:0]] = c.hold;
                        end
                    end
                    ACT_KEY: begin
                        if (c.code != 0) begin
                            s = 0;
                            while (s < NUM_SLOTS && key_code[s] != c.code && key_cnt[s] != 0)
                                s++;
                            if (s < NUM_SLOTS) begin
                                if (c.hold != 0) key_code[s] = c.code;
                                key_cnt[s] = c.hold;
                            end
                        end
                    end
                    ACT_DELAY: begin
                        delay_pending = 1;
                        delay_left    = int'(c.dly);
                    end
                    default: ;
                endcase
            end
            if (delay_pending) begin
                delay_left -= int'(tick_ms_q);
                if (delay_left < 0) delay_pending = 0;
            end

            changed = (mod_bits != last_mods);
            for (i = 0; i < NUM_SLOTS; i++)
                if (key_code[i] != last_keys[i]) changed = 1;
            if (changed) begin
                last_mods = mod_bits;
                for (i = 0; i < NUM_SLOTS; i++) last_keys[i] = key_code[i];
                repeats_left = REPEAT_COUNT;
                rep.sent = 1'b1;
            end else if (repeats_left != 0) begin
                repeats_left--;
                rep.sent = 1'b1;
            end
            rep.mods = rep.sent ? mod_bits : 8'h00;
            for (i = 0; i < NUM_SLOTS; i++) rep.keys[i] = rep.sent ? key_code[i] : 8'h00;

            for (i = 0; i < NUM_MODS; i++) begin
                if (mod_cnt[i] > 0) mod_cnt[i]--;
                if (mod_cnt[i] == 0) begin
                    mod_bits[i] = 1'b0;
                end else begin
                    mod_bits[i] = 1'b1;
                    rep.released = 1'b0;
                end
            end
            // count down, clear expired keys, slide live keys toward slot 0
            for (i = 0; i < NUM_SLOTS; i++) begin
                if (key_cnt[i] > 0) key_cnt[i]--;
                if (key_cnt[i] == 0) key_code[i] = '0;
                else rep.released = 1'b0;
                t = i;
                while (t > 0 && key_cnt[t-1] == 0 && key_cnt[t] != 0) begin
                    key_cnt[t-1]  = key_cnt[t];
                    key_code[t-1] = key_code[t];
                    key_cnt[t]    = '0;
                    key_code[t]   = '0;
                    t--;
                end
            end
            pending_reports.push_back(rep);
        end
    endtask

    task automatic send_item(input t_action act, input logic [7:0] code,
                             input logic [6:0] hold, input logic [14:0] dly);
        t_queued_cmd item;
        item = '{action: act, code: code, hold: hold, dly: dly};
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_action     <= act;
        i_code       <= code;
        i_hold_ticks <= hold;
        i_delay_ms   <= dly;
        do @(posedge i_clk); while (busy);
        advance_keyboard_model(item);
    endtask

    // Hold start low until every tick result is back and the engine is quiet.
    task automatic settle_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_reports.size() != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_tick_ms(input logic [7:0] value);
        settle_idle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TICK_MS;
        pwdata  <= ($urandom() & 32'hFFFF_FF00) | {24'h0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tick_ms_q = value;
        // read back
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== tick_ms_q) report_mismatch("tick_ms readback", prdata, tick_ms_q);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_tick();
        send_item(ACT_TICK, 8'($urandom()), 7'($urandom()), 15'($urandom()));
    endtask

    task automatic send_random_command();
        int          r;
        int          cap;
        logic [7:0]  code;
        logic [6:0]  hold;
        logic [14:0] dly;
        r    = $urandom_range(99);
        code = 8'($urandom());
        hold = ($urandom_range(99) < 70) ? 7'($urandom_range(6)) : 7'($urandom());
        dly  = 15'($urandom());
        if (r < 42) begin
            if ($urandom_range(9) < 7) code = 8'($urandom_range(1, 12));
            else if ($urandom_range(2) == 0) code = 8'h00;
            send_item(ACT_KEY, code, hold, dly);
        end else if (r < 80) begin
            code = ($urandom_range(99) < 85) ? 8'($urandom_range(NUM_MODS - 1))
                                             : 8'($urandom_range(255, NUM_MODS));
            send_item(ACT_MOD, code, hold, dly);
        end else if (r < 85) begin
            cap = int'(tick_ms_q) * 150;
            if (cap > 32767) cap = 32767;
            if ($urandom_range(19) == 0) dly = 15'($urandom_range(cap));
            else dly = 15'($urandom_range(int'(tick_ms_q) * 4));
            send_item(ACT_DELAY, code, hold, dly);
        end else begin
            send_item(t_action'($urandom_range(3, 1)), code, hold, dly);
        end
    endtask

    task automatic test_modifier_presses();
        send_item(ACT_MOD, 8'd0, 7'd127, 15'h7FFF);
        send_item(ACT_MOD, 8'd7, 7'd1, 15'd0);
        send_item(ACT_MOD, 8'd8, 7'd5, 15'd0);      // index out of range
        send_item(ACT_MOD, 8'd255, 7'd3, 15'd0);
        send_tick();
        send_tick();
        send_item(ACT_MOD, 8'd0, 7'd0, 15'd0);      // release
        send_tick();
        send_tick();
    endtask

    task automatic test_key_presses();
        send_item(ACT_KEY, 8'd255, 7'd3, 15'd0);
        send_item(ACT_KEY, 8'd0, 7'd9, 15'd0);      // code 0 is dropped
        send_item(ACT_KEY, 8'd1, 7'd1, 15'd0);
        send_item(ACT_KEY, 8'd255, 7'd127, 15'd0);  // same code refreshes its slot
        send_tick();
        send_tick();
        send_item(ACT_KEY, 8'd255, 7'd0, 15'd0);
        send_tick();
        send_tick();
    endtask

    task automatic test_delays();
        write_tick_ms(8'd255);
        send_item(ACT_DELAY, 8'd0, 7'd0, 15'd0);    // expires on the tick that takes it
        send_item(ACT_KEY, 8'd5, 7'd2, 15'd0);
        send_item(ACT_DELAY, 8'd0, 7'd0, 15'd300);
        send_item(ACT_KEY, 8'd6, 7'd1, 15'd0);
        repeat (4) send_tick();
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input logic [7:0] tick_ms_value);
        int n_sent;
        int burst;
        write_tick_ms(tick_ms_value);
        sender_idle_pct = idle_pct;
        n_sent = 0;
        while (n_sent < n_items) begin
            // long bursts can overflow the command queue
            burst = ($urandom_range(9) == 0) ? $urandom_range(24, 16) : $urandom_range(5);
            repeat (burst) send_random_command();
            n_sent += burst;
            burst = $urandom_range(6, 1);
            repeat (burst) send_tick();
            n_sent += burst;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_tick_report want;
        logic [7:0]   got_keys [NUM_SLOTS];
        got_keys = '{o_key_slot0, o_key_slot1, o_key_slot2,
                     o_key_slot3, o_key_slot4, o_key_slot5};
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("result with no tick pending", 1, 0);
            end else begin
                want = pending_reports.pop_front();
                if (o_report_sent !== want.sent)
                    report_mismatch("report_sent", o_report_sent, want.sent);
                if (o_modifiers !== want.mods)
                    report_mismatch("modifiers", o_modifiers, want.mods);
                for (int s = 0; s < NUM_SLOTS; s++)
                    if (got_keys[s] !== want.keys[s])
                        report_mismatch($sformatf("key_slot%0d", s), got_keys[s], want.keys[s]);
                if (o_all_released !== want.released)
                    report_mismatch("all_released", o_all_released, want.released);
            end
        end
    end

    initial begin
        int waited;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_action     = ACT_TICK;
        i_code       = '0;
        i_hold_ticks = '0;
        i_delay_ms   = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = REG_TICK_MS;
        pwdata       = '0;
        clear_keyboard_model();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 23;
        test_modifier_presses();
        test_key_presses();
        test_delays();
        test_random_traffic(550, 23, 8'd1);
        test_random_traffic(550, 88, 8'd255);
        test_random_traffic(550, 0, 8'($urandom_range(254, 2)));

        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_reports.size() != 0)
            report_mismatch("tick results never arrived", 0, pending_reports.size());

        if (n_mismatch == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: hid_keyboard_report_engine_unit.f
rtl/hkre_pkg.sv
rtl/hkre_ram.sv
rtl/hkre_front.sv
rtl/hkre_back.sv
rtl/hid_keyboard_report_engine_unit.sv
rtl/hkre_checker.sv
tb/tb.sv
